[sv/lmtf_pkg.sv]
// Package with command codes and field widths for the move-to-front cache.
`default_nettype none
package lmtf_pkg;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned CFG_W = 5;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
endpackage
`default_nettype wire

[sv/lru_move_to_front_cache_unit.sv]
// Top level of the fully associative move-to-front key/value cache.
// A command beat is accepted in IDLE and then runs through four states. EXEC
// compares every key held in flip-flops in parallel, picks the slot and reads
// the value RAM at it. OUT updates the ranks, writes both value RAM copies for
// an insert and registers the command's own result fields. WAIT reads the
// front-value RAM copy at the new rank-0 slot. FRONT adds the front value and
// both counters and loads the output register. The next command can be
// accepted only once FRONT has returned to IDLE. While an earlier result
// still waits in the output register, a new command runs up to FRONT and
// holds there until the output register is free. Keys stay in flip-flops
// because every key is compared at once; values live in synchronous RAM.
// Capacity saturates to 2 below and ENTRIES above.
`default_nettype none
module lru_move_to_front_cache_unit #(
    parameter int unsigned ENTRIES     = 16,
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write: capacity.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [4:0]   i_cfg_data,
    // tdata: cmd[1:0], key, value, zero fill.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [((2+KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tdata: matched, found_value[32], released, released_key[32],
    // released_value[32], front_valid, front_value[32], hit_total[32],
    // miss_total[32], zero fill.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [199:0] m_axis_tdata
);
    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned RW = $clog2(ENTRIES);
    localparam int unsigned OW = $clog2(ENTRIES+1);

    // Control state codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_OUT   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_FRONT = 3'd4;

    logic [2:0]                 r_state;
    logic [4:0]                 r_cap;
    logic [KEY_WIDTH-1:0]       r_keys [ENTRIES];
    logic [ENTRIES-1:0]         r_valid;
    logic [RW-1:0]              r_rank [ENTRIES];
    logic [OW-1:0]              r_occ;
    logic [31:0]                r_hits, r_miss;
    logic [1:0]                 r_cmd;
    logic [KEY_WIDTH-1:0]       r_key;
    logic [VALUE_WIDTH-1:0]     r_val;
    logic                       r_hit;
    logic [IW-1:0]              r_slot;
    logic                       r_rel;
    logic [KEY_WIDTH-1:0]       r_rkey;
    logic [IW-1:0]              r_free;
    logic                       r_has_free;
    logic                       r_ovalid;
    logic [97:0]                r_part;
    logic [199:0]               r_odata;

    // Capacity saturation.
    logic [OW:0] w_cap;
    always_comb begin
        if (r_cap < 5'd2) begin
            w_cap = (OW+1)'(2);
        end else if (int'(r_cap) > int'(ENTRIES)) begin
            w_cap = (OW+1)'(ENTRIES);
        end else begin
            w_cap = (OW+1)'(r_cap);
        end
    end

    // Key match per slot.
    logic [ENTRIES-1:0] w_match;
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && r_keys[i] == r_key;
        end
    end

    // Valid ranks are always 0 .. occupancy-1, so the least recent slot
    // carries rank occupancy-1 and the most recent match has no matching
    // slot of lower rank.
    logic [RW-1:0] w_last_rank;
    assign w_last_rank = RW'(r_occ - 1'b1);

    // Parallel compare: most recent matching slot, least recent slot, first free slot.
    logic [ENTRIES-1:0] w_best;
    logic          w_hit, w_lru_ok, w_free_ok;
    logic [IW-1:0] w_hit_i, w_lru_i, w_free_i;
    always_comb begin
        w_hit = 1'b0; w_hit_i = '0;
        w_lru_ok = 1'b0; w_lru_i = '0;
        w_free_ok = 1'b0; w_free_i = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_best[i] = w_match[i];
            for (int j = 0; j < ENTRIES; j++) begin
                if (w_match[j] && r_rank[j] < r_rank[i]) begin
                    w_best[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_best[i]) begin
                w_hit = 1'b1; w_hit_i = IW'(i);
            end
            if (r_valid[i] && r_rank[i] == w_last_rank) begin
                w_lru_ok = 1'b1; w_lru_i = IW'(i);
            end
            if (!r_valid[i] && !w_free_ok) begin
                w_free_ok = 1'b1; w_free_i = IW'(i);
            end
        end
    end

    logic w_evict;
    assign w_evict = ({1'b0, r_occ} >= w_cap) && w_lru_ok;

    // Front slot: valid entry holding rank 0.
    logic          w_fr_ok;
    logic [IW-1:0] w_fr_i;
    always_comb begin
        w_fr_ok = 1'b0; w_fr_i = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && r_rank[i] == '0 && !w_fr_ok) begin
                w_fr_ok = 1'b1; w_fr_i = IW'(i);
            end
        end
    end

    // Value RAM for lookups and a mirror for the front value.
    logic                   w_we;
    logic [IW-1:0]          w_waddr, w_raddr;
    logic [VALUE_WIDTH-1:0] w_rdata, w_fdata;
    always_comb begin
        if (r_cmd == lmtf_pkg::CMD_INSERT) begin
            w_raddr = w_lru_i;
        end else begin
            w_raddr = w_hit_i;
        end
    end
    assign w_we = (r_state == ST_OUT) && r_cmd == lmtf_pkg::CMD_INSERT && r_has_free;
    assign w_waddr = r_free;

    lmtf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(ENTRIES)) u_val (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_val),
        .i_raddr(w_raddr), .o_rdata(w_rdata));
    lmtf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(ENTRIES)) u_front (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_val),
        .i_raddr(w_fr_i), .o_rdata(w_fdata));

    // The finished beat moves to the output register once it is free.
    logic w_emit;
    assign w_emit = (r_state == ST_FRONT) && (!r_ovalid || m_axis_tready);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Sequencer: EXEC latches the compare, OUT applies the update, WAIT reads
    // the front RAM at the new front slot, FRONT emits the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= lmtf_pkg::CAP_RESET;
            r_valid <= '0;
            r_occ   <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) r_cap <= i_cfg_data;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd <= s_axis_tdata[1:0];
                        r_key <= s_axis_tdata[2 +: KEY_WIDTH];
                        r_val <= s_axis_tdata[2+KEY_WIDTH +: VALUE_WIDTH];
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_hit <= w_hit;
                    if (r_cmd == lmtf_pkg::CMD_INSERT) begin
                        r_rel <= w_evict;
                        r_slot <= w_lru_i;
                        r_rkey <= r_keys[w_lru_i];
                    end else begin
                        r_rel <= (r_cmd == lmtf_pkg::CMD_INVAL) && w_hit;
                        r_slot <= w_hit_i;
                        r_rkey <= r_keys[w_hit_i];
                    end
                    r_free <= w_evict ? (w_free_ok ? w_free_i : w_lru_i) : w_free_i;
                    r_has_free <= w_evict || w_free_ok;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    case (r_cmd)
                        lmtf_pkg::CMD_FIND: begin
                            if (r_hit) begin
                                for (int i = 0; i < ENTRIES; i++) begin
                                    if (IW'(i) == r_slot) begin
                                        r_rank[i] <= '0;
                                    end else if (r_valid[i] && r_rank[i] < r_rank[r_slot]) begin
                                        r_rank[i] <= r_rank[i] + 1'b1;
                                    end
                                end
                                r_hits <= r_hits + 1'b1;
                            end else begin
                                r_miss <= r_miss + 1'b1;
                            end
                        end
                        lmtf_pkg::CMD_INSERT: begin
                            if (r_has_free) begin
                                for (int i = 0; i < ENTRIES; i++) begin
                                    if (IW'(i) == r_free) begin
                                        r_valid[i] <= 1'b1;
                                        r_rank[i] <= '0;
                                    end else if (r_rel && IW'(i) == r_slot) begin
                                        r_valid[i] <= 1'b0;
                                    end else if (r_valid[i]) begin
                                        r_rank[i] <= r_rank[i] + 1'b1;
                                    end
                                end
                                r_keys[r_free] <= r_key;
                                if (!r_rel) r_occ <= r_occ + 1'b1;
                            end
                        end
                        lmtf_pkg::CMD_INVAL: begin
                            if (r_hit) begin
                                for (int i = 0; i < ENTRIES; i++)
                                    if (r_valid[i] && r_rank[i] > r_rank[r_slot])
                                        r_rank[i] <= r_rank[i] - 1'b1;
                                r_valid[r_slot] <= 1'b0;
                                r_occ <= r_occ - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // Capture the command's own fields; front and counters follow.
                    r_part <= {(r_rel ? 32'(w_rdata) : 32'd0),
                               (r_rel ? 32'(r_rkey) : 32'd0),
                               r_rel,
                               ((r_hit && r_cmd == lmtf_pkg::CMD_FIND) ?
                                   32'(w_rdata) : 32'd0),
                               r_hit && (r_cmd == lmtf_pkg::CMD_FIND ||
                                         r_cmd == lmtf_pkg::CMD_INVAL)};
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    r_state <= ST_FRONT;
                end
                ST_FRONT: begin
                    if (w_emit) begin
                        r_odata <= {5'b0, r_miss, r_hits,
                                    (w_fr_ok ? 32'(w_fdata) : 32'd0), w_fr_ok, r_part};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/lmtf_ram.sv]
// Generic simple dual-port synchronous RAM with a registered read.
`default_nettype none
module lmtf_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[sv/lmtf_checker.sv]
// Port-level checker for the move-to-front cache, bound to the top level.
`default_nettype none
module lmtf_port_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [199:0] m_axis_tdata
);
    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");
    // Found value is zero when nothing matched.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
        else $error("found value without a match");
    // No front value without a front entry.
    a_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[98] |-> m_axis_tdata[130:99] == 32'd0)
        else $error("front value without front entry");
    // Accepted command is not immediately followed by another acceptance.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back command accepted");
endmodule

bind lru_move_to_front_cache_unit lmtf_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));
`default_nettype wire
